// ===== hw/rtl/utf8d_pkg.sv =====
`timescale 1ns / 1ps

package utf8d_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned LEFT_W = 2;

    // Lead byte thresholds and payload masks
    localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'd127;
    localparam logic [BYTE_W-1:0] LEAD2_MIN  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MIN  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MIN  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;

    localparam int unsigned CONT_BITS = 6;

    // Result queue sizing
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            truncated;
        logic            run_last;
    } res_t;

    typedef struct packed {
        logic [CP_W-1:0]   partial_value;
        logic [LEFT_W-1:0] bytes_left;
    } dec_state_t;

    // Results produced by one byte: up to two, slot 0 first
    typedef struct packed {
        logic [1:0] count;
        res_t       res0;
        res_t       res1;
    } push_t;

endpackage

// ===== hw/rtl/utf8d_if.sv =====
`timescale 1ns / 1ps

interface utf8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface utf8d_cp_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        truncated;
    logic        run_last;

    modport source (output valid, output code_point, output truncated, output run_last,
                    input ready);
    modport sink   (input valid, input code_point, input truncated, input run_last,
                    output ready);
endinterface

// ===== hw/rtl/utf8d_decode.sv =====
`timescale 1ns / 1ps

module utf8d_decode (
    input  logic [7:0]           text_byte,
    input  logic                 end_of_text,
    input  utf8d_pkg::dec_state_t state_cur,
    output utf8d_pkg::dec_state_t state_nxt,
    output utf8d_pkg::push_t      push
);
    import utf8d_pkg::*;

    logic [CP_W-1:0]   pv;
    logic [LEFT_W-1:0] bl;
    logic [CP_W-1:0]   pv_cont;
    logic [LEFT_W-1:0] bl_cont;
    logic              as_lead;
    logic [1:0]        n;
    res_t              r0;
    res_t              r1;
    res_t              emit;
    logic              have_emit;

    always_comb
    begin
        pv        = state_cur.partial_value;
        bl        = state_cur.bytes_left;
        pv_cont   = {state_cur.partial_value[CP_W-CONT_BITS-1:0],
                     text_byte[CONT_BITS-1:0] & CONT_MASK[CONT_BITS-1:0]};
        bl_cont   = state_cur.bytes_left - 2'd1;
        as_lead   = 1'b1;
        n         = 2'd0;
        r0        = '0;
        r1        = '0;
        emit      = '0;
        have_emit = 1'b0;

        // Pending sequence: extend it or cut it short
        if (state_cur.bytes_left != '0)
        begin
            if (text_byte > ASCII_MAX)
            begin
                as_lead = 1'b0;
                if (bl_cont == '0)
                begin
                    r0 = '{code_point: pv_cont, truncated: 1'b0, run_last: 1'b0};
                    n  = 2'd1;
                    pv = '0;
                    bl = '0;
                end
                else if (end_of_text)
                begin
                    r0 = '{code_point: pv_cont, truncated: 1'b1, run_last: 1'b0};
                    n  = 2'd1;
                    pv = '0;
                    bl = '0;
                end
                else
                begin
                    pv = pv_cont;
                    bl = bl_cont;
                end
            end
            else
            begin
                r0 = '{code_point: state_cur.partial_value, truncated: 1'b1,
                       run_last: 1'b0};
                n  = 2'd1;
                pv = '0;
                bl = '0;
            end
        end

        // Lead position
        if (as_lead)
        begin
            if (text_byte < LEAD2_MIN)
            begin
                emit      = '{code_point: {{(CP_W-BYTE_W){1'b0}}, text_byte},
                              truncated: 1'b0, run_last: 1'b0};
                have_emit = 1'b1;
            end
            else
            begin
                if (text_byte >= LEAD4_MIN)
                begin
                    pv = {{(CP_W-BYTE_W){1'b0}}, text_byte & LEAD4_MASK};
                    bl = 2'd3;
                end
                else if (text_byte >= LEAD3_MIN)
                begin
                    pv = {{(CP_W-BYTE_W){1'b0}}, text_byte & LEAD3_MASK};
                    bl = 2'd2;
                end
                else
                begin
                    pv = {{(CP_W-BYTE_W){1'b0}}, text_byte & LEAD2_MASK};
                    bl = 2'd1;
                end
                if (end_of_text)
                begin
                    emit      = '{code_point: pv, truncated: 1'b1, run_last: 1'b0};
                    have_emit = 1'b1;
                    pv        = '0;
                    bl        = '0;
                end
            end
            if (have_emit)
            begin
                if (n == 2'd0)
                    r0 = emit;
                else
                    r1 = emit;
                n = n + 2'd1;
            end
        end

        // Mark the last result of this byte
        if (n == 2'd2)
            r1.run_last = 1'b1;
        else if (n == 2'd1)
            r0.run_last = 1'b1;
    end

    assign state_nxt = '{partial_value: pv, bytes_left: bl};
    assign push      = '{count: n, res0: r0, res1: r1};

endmodule

// ===== hw/rtl/utf8d_res_queue.sv =====
`timescale 1ns / 1ps

module utf8d_res_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  utf8d_pkg::push_t push,
    output logic             room_two,
    utf8d_cp_if.source       cp_out
);
    import utf8d_pkg::*;

    res_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic [QPTR_W-1:0] wr_ptr_inc;
    logic              pop;
    res_t              head;

    assign pop        = cp_out.valid && cp_out.ready;
    assign wr_ptr_inc = wr_ptr_reg + QPTR_W'(1);
    assign room_two   = count_reg <= QCNT_W'(QDEPTH - 2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.res0;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_inc] <= push.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head              = entry_reg[rd_ptr_reg];
    assign cp_out.valid      = count_reg != '0;
    assign cp_out.code_point = head.code_point;
    assign cp_out.truncated  = head.truncated;
    assign cp_out.run_last   = head.run_last;

endmodule

// ===== hw/rtl/utf8_to_codepoint_decoder.sv =====
`timescale 1ns / 1ps

// Channel   Modport  Payload                                  Request
// --------  -------  ---------------------------------------  ------------------------
// byte_in   sink     text_byte[7:0], end_of_text              one raw byte of UTF-8 text
// cp_out    source   code_point[20:0], truncated, run_last    one decoded code point
//
// One byte per cycle while the queue has room for two results. A byte is held in the
// input register, is decoded there and writes its zero, one or two results into a
// four-entry result queue. The first result is offered once it is in the queue and
// is taken at a clock edge on which the sink is ready.
// The input register advances only while the queue has room for two results, so a
// stalled sink backs up into byte_in once three results wait; nothing is dropped.
// Reset (rst_n, async, active low) empties both stages and clears the decode state.

module utf8_to_codepoint_decoder (
    input  logic        clk,
    input  logic        rst_n,
    utf8d_byte_if.sink  byte_in,
    utf8d_cp_if.source  cp_out
);
    import utf8d_pkg::*;

    // Input register
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_eot_reg;

    // Decode state: pending partial value and continuation bytes still expected
    dec_state_t        state_reg;
    dec_state_t        state_next;
    dec_state_t        state_dec;

    push_t             push_dec;
    push_t             push;
    logic              room_two;
    logic              fire;
    logic              take;

    // Decode the registered byte once the queue can absorb its worst case
    assign fire = in_valid_reg && room_two;
    assign take = byte_in.valid && byte_in.ready;

    // Accept a new request whenever the input register empties this cycle
    assign byte_in.ready = !in_valid_reg || fire;

    utf8d_decode u_decode (
        .text_byte   (in_byte_reg),
        .end_of_text (in_eot_reg),
        .state_cur   (state_reg),
        .state_nxt   (state_dec),
        .push        (push_dec)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        state_next    = state_reg;
        push          = '0;
        if (fire)
        begin
            // Advance the decode state and hand the results to the queue
            state_next    = state_dec;
            push          = push_dec;
            in_valid_next = 1'b0;
        end
        if (take)
            in_valid_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg <= byte_in.text_byte;
            in_eot_reg  <= byte_in.end_of_text;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    utf8d_res_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room_two (room_two),
        .cp_out   (cp_out)
    );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import utf8d_pkg::*;

    // Watchdog: ends the run as failed when it reaches the cycle limit
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned HOLD_CYCLES = 150;

    logic clk;
    logic rst_n;

    utf8d_byte_if byte_ch ();
    utf8d_cp_if   cp_ch ();

    utf8_to_codepoint_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_ch.sink),
        .cp_out  (cp_ch.source)
    );

    // Decoder state as the scoreboard sees it
    logic [CP_W-1:0]   seq_value;
    logic [LEFT_W-1:0] seq_left;

    // Code points still owed by the block, oldest first
    res_t expected_cps[$];

    int unsigned mismatches = 0;
    int unsigned cycles;
    int unsigned bytes_sent;

    // Percent chance of a gap before each request, per side
    int unsigned in_idle_pct;
    int unsigned out_idle_pct;

    // Number of long receiver hold-offs asked for; the sink process counts each out
    int unsigned hold_request;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap(input int unsigned pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Advance the decode state by one accepted byte and queue the code points
    // it produces: at most a truncated partial plus one more.
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        res_t outs[2];
        int   n;
        logic as_lead;
        n       = 0;
        as_lead = 1'b1;
        outs[0] = '0;
        outs[1] = '0;

        if (seq_left != '0)
        begin
            if (b > ASCII_MAX)
            begin
                // Lenient: any high byte is a continuation, shift in six bits
                seq_value = {seq_value[CP_W-CONT_BITS-1:0], b[5:0]};
                seq_left  = seq_left - 2'd1;
                if (seq_left == '0)
                begin
                    outs[n].code_point = seq_value;
                    n++;
                    seq_value = '0;
                end
                else if (last)
                begin
                    // End of text cuts the sequence short
                    outs[n].code_point = seq_value;
                    outs[n].truncated  = 1'b1;
                    n++;
                    seq_value = '0;
                    seq_left  = '0;
                end
                as_lead = 1'b0;
            end
            else
            begin
                // A low byte cuts the sequence; flush the partial, then decode it as a lead
                outs[n].code_point = seq_value;
                outs[n].truncated  = 1'b1;
                n++;
                seq_value = '0;
                seq_left  = '0;
            end
        end

        if (as_lead)
        begin
            if (b < LEAD2_MIN)
            begin
                // ASCII and stray continuation bytes pass through as themselves
                outs[n].code_point = CP_W'(b);
                n++;
            end
            else
            begin
                if (b >= LEAD4_MIN)
                begin
                    seq_value = CP_W'(b & LEAD4_MASK);
                    seq_left  = 2'd3;
                end
                else if (b >= LEAD3_MIN)
                begin
                    seq_value = CP_W'(b & LEAD3_MASK);
                    seq_left  = 2'd2;
                end
                else
                begin
                    seq_value = CP_W'(b & LEAD2_MASK);
                    seq_left  = 2'd1;
                end
                if (last)
                begin
                    // Lead byte at end of text: emit the lead bits alone, truncated
                    outs[n].code_point = seq_value;
                    outs[n].truncated  = 1'b1;
                    n++;
                    seq_value = '0;
                    seq_left  = '0;
                end
            end
        end

        if (n > 0)
            outs[n-1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_cps.push_back(outs[i]);
    endfunction

    function automatic void report_mismatch(input string what, input logic [20:0] want,
                                            input logic [20:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: expected 0x%06h, got 0x%06h",
                     $realtime, what, want, got);
    endfunction

    // Compare one accepted code point against the oldest one owed
    function automatic void check_cp();
        res_t want;
        if (expected_cps.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] unexpected code point 0x%06h truncated %0b run_last %0b",
                         $realtime, cp_ch.code_point, cp_ch.truncated, cp_ch.run_last);
            return;
        end
        want = expected_cps.pop_front();
        if (cp_ch.code_point !== want.code_point)
            report_mismatch("code_point", want.code_point, cp_ch.code_point);
        if (cp_ch.truncated !== want.truncated)
            report_mismatch("truncated", 21'(want.truncated), 21'(cp_ch.truncated));
        if (cp_ch.run_last !== want.run_last)
            report_mismatch("run_last", 21'(want.run_last), 21'(cp_ch.run_last));
    endfunction

    // Code point sink: check every request taken at this edge, then pick
    // ready for the next cycle. Values read here are the ones before the edge.
    initial
    begin : cp_sink
        int unsigned stall;
        int unsigned hold;
        int unsigned hold_seen;
        logic        next_ready;
        stall     = 0;
        hold      = 0;
        hold_seen = 0;
        cp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (cp_ch.valid && cp_ch.ready)
                check_cp();
            if (hold_request != hold_seen)
            begin
                hold      = HOLD_CYCLES;
                hold_seen = hold_request;
            end
            if (hold > 0)
            begin
                next_ready = 1'b0;
                hold--;
            end
            else if (stall > 0)
            begin
                next_ready = 1'b0;
                stall--;
            end
            else
            begin
                stall = pick_gap(out_idle_pct);
                if (stall > 0)
                begin
                    next_ready = 1'b0;
                    stall--;
                end
                else
                begin
                    next_ready = 1'b1;
                end
            end
            cp_ch.ready <= next_ready;
        end
    end

    // Offer one byte after an optional gap and hold it until taken.
    // Valid stays high on return so a back-to-back request needs no re-raise.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = pick_gap(in_idle_pct);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.text_byte   <= b;
        byte_ch.end_of_text <= last;
        do @(posedge clk); while (!byte_ch.ready);
        decode_byte(b, last);
        bytes_sent++;
    endtask

    // Drop valid and wait until every owed code point has come back
    task automatic wait_for_drain();
        byte_ch.valid <= 1'b0;
        while (expected_cps.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] rand_cont();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Lead byte for a sequence of len bytes in total (2..4)
    function automatic logic [7:0] rand_lead(input int unsigned len);
        if (len == 2)
            return LEAD2_MIN | 8'($urandom_range(0, 31));
        if (len == 3)
            return LEAD3_MIN | 8'($urandom_range(0, 15));
        return LEAD4_MIN | 8'($urandom_range(0, 15));
    endfunction

    // One well-formed character, one broken sequence, or a noise byte
    task automatic send_random_chunk();
        int unsigned pick;
        int unsigned len;
        int unsigned kept;
        pick = $urandom_range(0, 99);
        if (pick < 65)
        begin
            len = $urandom_range(1, 4);
            if (len == 1)
            begin
                send_byte(8'($urandom_range(0, 127)), $urandom_range(0, 19) == 0);
            end
            else
            begin
                send_byte(rand_lead(len), 1'b0);
                for (int i = 1; i < len; i++)
                    send_byte(rand_cont(), (i == len - 1) && ($urandom_range(0, 19) == 0));
            end
        end
        else if (pick < 82)
        begin
            // Broken: lead plus too few continuations, then cut by a low byte or end of text
            len  = $urandom_range(2, 4);
            kept = $urandom_range(0, len - 2);
            if (kept > 0 && $urandom_range(0, 2) == 0)
            begin
                send_byte(rand_lead(len), 1'b0);
                for (int i = 1; i <= kept; i++)
                    send_byte(rand_cont(), i == kept);
            end
            else
            begin
                send_byte(rand_lead(len), 1'b0);
                for (int i = 1; i <= kept; i++)
                    send_byte(rand_cont(), 1'b0);
                send_byte(8'($urandom_range(0, 127)), $urandom_range(0, 7) == 0);
            end
        end
        else
        begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
    endtask

    // Field extremes and every cut-short case, by hand
    task automatic test_directed();
        in_idle_pct  = 30;
        out_idle_pct = 30;
        // Lead position: zero, top ASCII, both ends of the stray continuation range
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
        // Smallest two-byte, largest two-byte ending the text
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b1);
        // Three and four byte sequences, lowest and highest lead
        send_byte(8'hE0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // Cut by an ASCII byte, then cut by a zero byte
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h00, 1'b0);
        // End of text on a lead, then on a continuation mid-sequence
        send_byte(8'hF5, 1'b1);
        send_byte(8'hE1, 1'b0);
        send_byte(8'h85, 1'b1);
    endtask

    // Mostly valid text with random content, gaps on both sides
    task automatic test_random_text(input int unsigned count);
        int unsigned stop_at;
        in_idle_pct  = 25;
        out_idle_pct = 25;
        stop_at      = bytes_sent + count;
        while (bytes_sent < stop_at)
            send_random_chunk();
    endtask

    // Full rate on both sides
    task automatic test_steady_stream(input int unsigned count);
        int unsigned stop_at;
        in_idle_pct  = 0;
        out_idle_pct = 0;
        stop_at      = bytes_sent + count;
        while (bytes_sent < stop_at)
            send_random_chunk();
    endtask

    // Hold the sink off while bytes keep coming so the result queue fills
    // and byte_in stalls; then release and let everything drain
    task automatic test_backpressure(input int unsigned count);
        int unsigned stop_at;
        in_idle_pct  = 0;
        out_idle_pct = 20;
        hold_request++;
        stop_at      = bytes_sent + count;
        while (bytes_sent < stop_at)
            send_random_chunk();
        wait_for_drain();
    endtask

    // Stop the sender until nothing is owed, then resume mid-stream
    task automatic test_drain_pause(input int unsigned count);
        int unsigned stop_at;
        in_idle_pct  = 15;
        out_idle_pct = 40;
        send_byte(rand_lead(3), 1'b0);
        send_byte(rand_cont(), 1'b0);
        wait_for_drain();
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
            send_random_chunk();
    endtask

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("utf8_to_codepoint_decoder verification failed");
        $finish;
    end

    initial
    begin : main
        rst_n                = 1'b0;
        byte_ch.valid       <= 1'b0;
        byte_ch.text_byte   <= '0;
        byte_ch.end_of_text <= 1'b0;
        seq_value    = '0;
        seq_left     = '0;
        bytes_sent   = 0;
        hold_request = 0;
        in_idle_pct  = 0;
        out_idle_pct = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_text(220);
        test_drain_pause(40);
        test_steady_stream(80);
        test_backpressure(60);
        test_random_text(180);

        // Let the last results arrive, then watch for stray ones
        wait_for_drain();
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("utf8_to_codepoint_decoder verification clean");
        else
            $display("utf8_to_codepoint_decoder verification failed");
        $finish;
    end

endmodule
